// File: src/time_history_ring_interpolator_core_defines.svh
`ifndef TIME_HISTORY_RING_INTERPOLATOR_CORE_DEFINES_SVH
`define TIME_HISTORY_RING_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define THRI_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define THRI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/thri_pkg.sv
package thri_pkg;

	localparam int HISTORY_DEPTH = 16;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int DIV_STEPS     = 16;
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + DIV_STEPS + 2);
	localparam int WALK_LAST     = HISTORY_DEPTH + 1;

	localparam logic [16:0] WEIGHT_ONE = 17'h10000;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] CFG_SEARCH_MODE = 2'd0;
	localparam logic [1:0] CFG_INV_STEP    = 2'd1;
	localparam logic [1:0] CFG_INDEX_TOL   = 2'd2;
	localparam logic [1:0] CFG_TIME_TOL    = 2'd3;

	localparam logic [1:0] RD_WALK = 2'd0;
	localparam logic [1:0] RD_A    = 2'd1;
	localparam logic [1:0] RD_B    = 2'd2;

	localparam logic [2:0] RES_ZERO   = 3'd0;
	localparam logic [2:0] RES_APPEND = 3'd1;
	localparam logic [2:0] RES_REMOVE = 3'd2;
	localparam logic [2:0] RES_EXACT  = 3'd3;
	localparam logic [2:0] RES_BLEND  = 3'd4;

	typedef struct packed {
		logic              load_in;
		logic              append;
		logic              remove;
		logic [1:0]        rd_sel;
		logic [SLOT_W-1:0] idx;
		logic              umul;
		logic              udec;
		logic              cap_a;
		logic              cap_b;
		logic              walk_load;
		logic              walk_hit;
		logic              div_load;
		logic              div_step;
		logic              div_done;
		logic              bl1;
		logic              bl2;
		logic              res_we;
		logic [2:0]        res_sel;
	} thri_cmd_t;

	typedef struct packed {
		logic search_mode;
		logic ufound;
		logic uexact;
		logic exact_now;
		logic bracket_now;
	} thri_stat_t;

endpackage

// File: src/thri_datapath.sv
module thri_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [31:0]        time_value,
	input  logic signed [31:0] sample_value,
	input  thri_pkg::thri_cmd_t cmd,
	output thri_pkg::thri_stat_t stat,
	output logic               found,
	output logic               exact_hit,
	output logic [3:0]         slot_a,
	output logic [3:0]         slot_b,
	output logic [16:0]        weight_a,
	output logic [16:0]        weight_b,
	output logic signed [31:0] value_out
);
	import thri_pkg::*;

	logic        search_mode_q;
	logic [31:0] inv_step_q;
	logic [15:0] index_tol_q;
	logic [15:0] time_tol_q;

	logic [SLOT_W-1:0]        newest_q;
	logic [HISTORY_DEPTH-1:0] valid_q;

	logic [31:0]        time_mem [HISTORY_DEPTH];
	logic signed [31:0] val_mem  [HISTORY_DEPTH];

	logic [SLOT_W-1:0]  rd_addr;
	logic [SLOT_W-1:0]  rd_slot_q;
	logic [31:0]        rd_time_q;
	logic signed [31:0] rd_val_q;

	logic [31:0]        t_q;
	logic [63:0]        prod_q;
	logic [SLOT_W-1:0]  slot_a_q, slot_b_q;
	logic [16:0]        wa_q, wb_q;
	logic               exact_q;
	logic signed [31:0] va_q, vb_q;

	logic [SLOT_W-1:0]  p_slot_q;
	logic [31:0]        p_time_q;
	logic signed [31:0] p_val_q;

	logic [31:0] rem_q, del_q;
	logic [15:0] quo_q;

	logic signed [49:0] pa_q, pb_q;

	logic [SLOT_W-1:0] newest_inc;
	assign newest_inc = newest_q + 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_mode_q <= 1'b0;
			inv_step_q    <= 32'd65536;
			index_tol_q   <= 16'd7;
			time_tol_q    <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SEARCH_MODE: search_mode_q <= cfg_data[0];
				CFG_INV_STEP:    inv_step_q    <= cfg_data;
				CFG_INDEX_TOL:   index_tol_q   <= cfg_data[15:0];
				CFG_TIME_TOL:    time_tol_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ring pointer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= SLOT_W'(HISTORY_DEPTH - 1);
			valid_q  <= '0;
		end else if (cmd.append) begin
			newest_q            <= newest_inc;
			valid_q[newest_inc] <= 1'b1;
		end else if (cmd.remove) begin
			newest_q          <= newest_q - 1'b1;
			valid_q[newest_q] <= 1'b0;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_A:    rd_addr = slot_a_q;
			RD_B:    rd_addr = slot_b_q;
			default: rd_addr = newest_q - cmd.idx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			time_mem[newest_inc] <= time_value;
			val_mem[newest_inc]  <= sample_value;
		end
		rd_time_q <= time_mem[rd_addr];
		rd_val_q  <= val_mem[rd_addr];
		rd_slot_q <= rd_addr;
	end

	// uniform indexing: distance of the product to the rounded-down or rounded-up index
	logic [31:0]       frac, tol32;
	logic [32:0]       frac_sum, up_dist;
	logic              carry, u_exact;
	logic [SLOT_W-1:0] base_sl, u_sa, u_sb;
	logic [16:0]       u_wb;

	always_comb begin
		frac     = prod_q[31:0];
		tol32    = {index_tol_q, 16'h0000};
		frac_sum = {1'b0, frac} + {1'b0, tol32};
		carry    = frac_sum[32];
		up_dist  = 33'h1_0000_0000 - {1'b0, frac};
		u_exact  = carry ? (up_dist < {1'b0, tol32}) : (frac < tol32);
		base_sl  = prod_q[32 +: SLOT_W];
		u_sb     = base_sl + 1'b1;
		u_sa     = (u_exact && carry) ? u_sb : base_sl;
		u_wb     = {1'b0, frac[31:16]};
	end

	// backward walk: p is the held slot, q the slot just read
	logic        p_valid, q_valid;
	logic [31:0] p_minus_t, t_minus_p;
	logic        near;

	always_comb begin
		p_valid   = valid_q[p_slot_q];
		q_valid   = valid_q[rd_slot_q];
		p_minus_t = p_time_q - t_q;
		t_minus_p = t_q - p_time_q;
		near      = (p_time_q >= t_q) ? (p_minus_t < {16'h0000, time_tol_q})
		                              : (t_minus_p < {16'h0000, time_tol_q});
	end

	assign stat.search_mode = search_mode_q;
	assign stat.ufound      = u_exact ? valid_q[u_sa] : (valid_q[base_sl] && valid_q[u_sb]);
	assign stat.uexact      = exact_q;
	assign stat.exact_now   = p_valid && near;
	assign stat.bracket_now = p_valid && q_valid && (p_time_q > t_q) && (t_q > rd_time_q);

	// restoring divider, one quotient bit a cycle
	logic [32:0] rem2;
	logic        div_ge;
	logic [32:0] rem_sub;
	assign rem2    = {rem_q, 1'b0};
	assign div_ge  = rem2 >= {1'b0, del_q};
	assign rem_sub = rem2 - {1'b0, del_q};

	always_ff @(posedge clk) begin
		if (cmd.load_in) t_q <= time_value;
		if (cmd.umul) prod_q <= t_q * inv_step_q;
		if (cmd.udec) begin
			exact_q  <= u_exact;
			slot_a_q <= u_sa;
			slot_b_q <= u_exact ? '0 : u_sb;
			wb_q     <= u_exact ? 17'd0 : u_wb;
			wa_q     <= u_exact ? WEIGHT_ONE : (WEIGHT_ONE - u_wb);
		end
		if (cmd.cap_a) va_q <= rd_val_q;
		if (cmd.cap_b) vb_q <= rd_val_q;
		if (cmd.walk_load) begin
			p_slot_q <= rd_slot_q;
			p_time_q <= rd_time_q;
			p_val_q  <= rd_val_q;
		end
		if (cmd.walk_hit) begin
			slot_a_q <= p_slot_q;
			va_q     <= p_val_q;
		end
		if (cmd.div_load) begin
			slot_a_q <= p_slot_q;
			slot_b_q <= rd_slot_q;
			va_q     <= p_val_q;
			vb_q     <= rd_val_q;
			rem_q    <= t_q - rd_time_q;
			del_q    <= p_time_q - rd_time_q;
			quo_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? rem_sub[31:0] : rem2[31:0];
			quo_q <= {quo_q[14:0], div_ge};
		end
		if (cmd.div_done) begin
			wa_q <= {1'b0, quo_q};
			wb_q <= WEIGHT_ONE - {1'b0, quo_q};
		end
		if (cmd.bl1) pa_q <= $signed({1'b0, wa_q}) * va_q;
		if (cmd.bl2) pb_q <= $signed({1'b0, wb_q}) * vb_q;
	end

	// round half up: add half an LSB, then floor
	logic signed [50:0] bsum;
	assign bsum = 51'(pa_q) + 51'(pb_q) + 51'sd32768;

	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			unique case (cmd.res_sel)
				RES_APPEND: begin
					found <= 1'b1; exact_hit <= 1'b0;
					slot_a <= 4'(newest_inc); slot_b <= 4'd0;
					weight_a <= 17'd0; weight_b <= 17'd0; value_out <= 32'sd0;
				end
				RES_REMOVE: begin
					found <= 1'b1; exact_hit <= 1'b0;
					slot_a <= 4'(newest_q); slot_b <= 4'd0;
					weight_a <= 17'd0; weight_b <= 17'd0; value_out <= 32'sd0;
				end
				RES_EXACT: begin
					found <= 1'b1; exact_hit <= 1'b1;
					slot_a <= 4'(slot_a_q); slot_b <= 4'd0;
					weight_a <= WEIGHT_ONE; weight_b <= 17'd0; value_out <= va_q;
				end
				RES_BLEND: begin
					found <= 1'b1; exact_hit <= 1'b0;
					slot_a <= 4'(slot_a_q); slot_b <= 4'(slot_b_q);
					weight_a <= wa_q; weight_b <= wb_q; value_out <= bsum[47:16];
				end
				default: begin
					found <= 1'b0; exact_hit <= 1'b0;
					slot_a <= 4'd0; slot_b <= 4'd0;
					weight_a <= 17'd0; weight_b <= 17'd0; value_out <= 32'sd0;
				end
			endcase
		end
	end

endmodule

// File: src/thri_ctrl.sv
`include "time_history_ring_interpolator_core_defines.svh"

module thri_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           operation,
	input  thri_pkg::thri_stat_t stat,
	output thri_pkg::thri_cmd_t  cmd,
	output logic                 busy,
	output logic                 done
);
	import thri_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_UMUL  = 4'd1;
	localparam logic [3:0] S_UDEC  = 4'd2;
	localparam logic [3:0] S_URDA  = 4'd3;
	localparam logic [3:0] S_URDB  = 4'd4;
	localparam logic [3:0] S_URDC  = 4'd5;
	localparam logic [3:0] S_SWALK = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_DWT   = 4'd8;
	localparam logic [3:0] S_BL1   = 4'd9;
	localparam logic [3:0] S_BL2   = 4'd10;
	localparam logic [3:0] S_BL3   = 4'd11;
	localparam logic [3:0] S_FINX  = 4'd12;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.idx = cnt_q[SLOT_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				cmd.rd_sel = RD_WALK;
				if (start) begin
					unique case (operation)
						OP_APPEND: begin
							cmd.append  = 1'b1;
							cmd.res_we  = 1'b1;
							cmd.res_sel = RES_APPEND;
						end
						OP_REMOVE: begin
							cmd.remove  = 1'b1;
							cmd.res_we  = 1'b1;
							cmd.res_sel = RES_REMOVE;
						end
						OP_QUERY: begin
							cmd.load_in = 1'b1;
							if (stat.search_mode) begin
								state_d = S_SWALK;
								cnt_d   = CNT_W'(1);
							end else begin
								state_d = S_UMUL;
							end
						end
						default: begin
							cmd.res_we  = 1'b1;
							cmd.res_sel = RES_ZERO;
						end
					endcase
				end
			end
			S_UMUL: begin
				cmd.umul = 1'b1;
				state_d  = S_UDEC;
			end
			S_UDEC: begin
				cmd.udec = 1'b1;
				if (stat.ufound) begin
					state_d = S_URDA;
				end else begin
					cmd.res_we  = 1'b1;
					cmd.res_sel = RES_ZERO;
					state_d     = S_IDLE;
				end
			end
			S_URDA: begin
				cmd.rd_sel = RD_A;
				state_d    = S_URDB;
			end
			S_URDB: begin
				cmd.cap_a  = 1'b1;
				cmd.rd_sel = RD_B;
				state_d    = stat.uexact ? S_FINX : S_URDC;
			end
			S_URDC: begin
				cmd.cap_b = 1'b1;
				state_d   = S_BL1;
			end
			S_SWALK: begin
				// reads run one slot ahead of the pair being checked
				cmd.rd_sel = RD_WALK;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					cmd.walk_load = 1'b1;
				end else if (stat.exact_now) begin
					cmd.walk_hit = 1'b1;
					cnt_d        = '0;
					state_d      = S_FINX;
				end else if (stat.bracket_now) begin
					cmd.div_load = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIV;
				end else if (cnt_q == CNT_W'(WALK_LAST)) begin
					cmd.res_we  = 1'b1;
					cmd.res_sel = RES_ZERO;
					cnt_d       = '0;
					state_d     = S_IDLE;
				end else begin
					cmd.walk_load = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_DWT;
				end
			end
			S_DWT: begin
				cmd.div_done = 1'b1;
				state_d      = S_BL1;
			end
			S_BL1: begin
				cmd.bl1 = 1'b1;
				state_d = S_BL2;
			end
			S_BL2: begin
				cmd.bl2 = 1'b1;
				state_d = S_BL3;
			end
			S_BL3: begin
				cmd.res_we  = 1'b1;
				cmd.res_sel = RES_BLEND;
				state_d     = S_IDLE;
			end
			S_FINX: begin
				cmd.res_we  = 1'b1;
				cmd.res_sel = RES_EXACT;
				state_d     = S_IDLE;
			end
			default: begin
				cnt_d   = '0;
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= cmd.res_we;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`THRI_ASSERT_NEXT(a_query_goes_busy, start && !busy && operation == OP_QUERY, state_q != S_IDLE, "query transaction did not leave idle")
	`THRI_ASSERT_IMPLIES(a_walk_bound, state_q == S_SWALK, cnt_q != '0 && cnt_q <= CNT_W'(WALK_LAST), "walk counter out of range")
	`THRI_ASSERT_IMPLIES(a_idle_counter, state_q == S_IDLE, cnt_q == '0, "counter not cleared in idle")

endmodule

// File: src/time_history_ring_interpolator_core.sv
// Ring of 16 time-stamped samples with linear interpolation. A transaction is taken when start
// is high and busy is low. Its result appears for one cycle with done high, and the receiver
// cannot stall it. Append, remove and the unused code give their result in the cycle after
// acceptance, and a new transaction may follow in that same cycle. A uniform query multiplies
// the time by the inverse step and decodes the slots, and ends there when they are not valid.
// Else it reads slot a and then slot b from the one-port sample memory; on an exact hit it
// ends once slot a is captured, else the two weight multiplies run before the blended result.
// A search query walks back through the ring one slot a cycle until an exact hit, a bracketing
// pair or a miss; a bracketing pair then goes through the bit-serial weight divider and the blend.
// Configuration writes are always taken (cfg_ready is high) and must be made while idle.
module time_history_ring_interpolator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [31:0]        time_value,
	input  logic signed [31:0] sample_value,
	output logic               done,
	output logic               found,
	output logic               exact_hit,
	output logic [3:0]         slot_a,
	output logic [3:0]         slot_b,
	output logic [16:0]        weight_a,
	output logic [16:0]        weight_b,
	output logic signed [31:0] value_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import thri_pkg::*;

	thri_cmd_t  cmd;
	thri_stat_t stat;

	assign cfg_ready = 1'b1;

	thri_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	thri_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.time_value   (time_value),
		.sample_value (sample_value),
		.cmd          (cmd),
		.stat         (stat),
		.found        (found),
		.exact_hit    (exact_hit),
		.slot_a       (slot_a),
		.slot_b       (slot_b),
		.weight_a     (weight_a),
		.weight_b     (weight_b),
		.value_out    (value_out)
	);

endmodule
